// File: rtl/core/dcr_pkg.sv
// Shared types, constants and pixel conversion for the dominant color block.
// No dependencies; used by dcr_table, dcr_ctrl and dominant_color_of_row.
package dcr_pkg;

  // Default table depth: one entry per pixel of the widest row
  localparam int MAX_ROW_WIDTH_DEF = 1024;

  localparam int COLOR_W = 32;
  localparam int COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;

  // Byte order register codes
  localparam logic MODE_SWAP_RB = 1'b0;
  localparam logic MODE_ROTATE  = 1'b1;

  // Register index of byte_order_mode
  localparam logic REG_BYTE_ORDER = 1'b0;

  // One table entry: color and its running count
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // Memory command from the controller to the table
  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    entry_t wr_entry;
  } mem_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_BEST
  } state_t;

  // Reorder a raw framebuffer word to ARGB
  function automatic logic [COLOR_W-1:0] to_argb(input logic [31:0] p, input logic mode);
    logic [COLOR_W-1:0] r;
    if (mode == MODE_ROTATE) begin
      r = {p[7:0], p[31:8]};
    end else begin
      r = (p & 32'hFF00FF00) | {8'h00, p[7:0], 16'h0000} | {24'h000000, p[23:16]};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/dcr_table.sv
// Color/count table: single-port-write, single-port-read memory, registered read.
// Depends on dcr_pkg for entry_t and mem_cmd_t.
module dcr_table #(
  parameter int MAX_ROW_WIDTH = dcr_pkg::MAX_ROW_WIDTH_DEF,
  parameter int ADDR_W        = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1
) (
  input  logic                clk,
  input  dcr_pkg::mem_cmd_t   cmd,
  input  logic [ADDR_W-1:0]   rd_addr,
  input  logic [ADDR_W-1:0]   wr_addr,
  output dcr_pkg::entry_t     rd_data
);

  dcr_pkg::entry_t mem [MAX_ROW_WIDTH];

  // Write port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_entry;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/dcr_ctrl.sv
// Controller: per-pixel linear search of the table, update, and end-of-row max scan.
// Depends on dcr_pkg; drives dcr_table through a mem_cmd_t command.
module dcr_ctrl #(
  parameter int MAX_ROW_WIDTH = dcr_pkg::MAX_ROW_WIDTH_DEF,
  parameter int ADDR_W        = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1,
  parameter int CNT_W         = $clog2(MAX_ROW_WIDTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [31:0]                   pixel_word,
  input  logic                          row_end,
  input  logic                          mode,
  output logic                          busy,
  output logic                          done,
  output logic [dcr_pkg::COLOR_W-1:0]   dominant_color,
  output logic [dcr_pkg::COUNT_W-1:0]   dominant_count,
  output dcr_pkg::mem_cmd_t             cmd,
  output logic [ADDR_W-1:0]             rd_addr,
  output logic [ADDR_W-1:0]             wr_addr,
  input  dcr_pkg::entry_t               rd_data
);

  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(MAX_ROW_WIDTH);

  dcr_pkg::state_t state, state_next;

  logic [dcr_pkg::COLOR_W-1:0] cur_color;
  logic                        cur_last;
  logic [CNT_W-1:0]            rd_idx;
  logic                        rd_valid;
  logic [ADDR_W-1:0]           rd_tag;
  logic                        hit;
  logic [ADDR_W-1:0]           hit_idx;
  logic [dcr_pkg::COUNT_W-1:0] hit_count;
  logic [CNT_W-1:0]            used;
  logic [dcr_pkg::COLOR_W-1:0] best_color;
  logic [dcr_pkg::COUNT_W-1:0] best_count;

  logic accept, rd_more, match, emit, has_room;

  assign busy     = (state != dcr_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign rd_more  = (rd_idx < used);
  assign match    = rd_valid && (rd_data.color == cur_color);
  assign has_room = (used < DEPTH);
  assign rd_addr  = rd_idx[ADDR_W-1:0];

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    wr_addr      = '0;
    emit         = 1'b0;
    unique case (state)
      dcr_pkg::ST_IDLE: begin
        if (start) begin
          state_next = dcr_pkg::ST_SCAN;
        end
      end
      dcr_pkg::ST_SCAN: begin
        if (match) begin
          state_next = dcr_pkg::ST_UPDATE;
        end else if (rd_more) begin
          cmd.rd_en = 1'b1;
        end else if (!rd_valid) begin
          state_next = dcr_pkg::ST_UPDATE;
        end
      end
      dcr_pkg::ST_UPDATE: begin
        if (hit) begin
          cmd.wr_en          = 1'b1;
          wr_addr            = hit_idx;
          cmd.wr_entry.color = cur_color;
          cmd.wr_entry.count = (hit_count == dcr_pkg::COUNT_MAX) ? hit_count
                                                                 : hit_count + 1'b1;
        end else if (has_room) begin
          cmd.wr_en          = 1'b1;
          wr_addr            = used[ADDR_W-1:0];
          cmd.wr_entry.color = cur_color;
          cmd.wr_entry.count = dcr_pkg::COUNT_W'(1);
        end
        state_next = cur_last ? dcr_pkg::ST_BEST : dcr_pkg::ST_IDLE;
      end
      dcr_pkg::ST_BEST: begin
        if (rd_more) begin
          cmd.rd_en = 1'b1;
        end else if (!rd_valid) begin
          emit       = 1'b1;
          state_next = dcr_pkg::ST_IDLE;
        end
      end
      default: state_next = dcr_pkg::ST_IDLE;
    endcase
  end

  // Control registers: read pipeline, fill count, best tracker, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      rd_idx     <= '0;
      used       <= '0;
      best_color <= '0;
      best_count <= '0;
      done       <= 1'b0;
      hit        <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
      done     <= emit;
      // advance the read pointer, rewind at start of each pass
      if (accept || state == dcr_pkg::ST_UPDATE) begin
        rd_idx <= '0;
      end else if (cmd.rd_en) begin
        rd_idx <= rd_idx + 1'b1;
      end
      // record a hit during the search
      if (accept) begin
        hit <= 1'b0;
      end else if (state == dcr_pkg::ST_SCAN && match) begin
        hit <= 1'b1;
      end
      // grow the table on a new color, drop it all at row end
      if (emit) begin
        used <= '0;
      end else if (state == dcr_pkg::ST_UPDATE && !hit && has_room) begin
        used <= used + 1'b1;
      end
      // track the maximum, first seen wins a tie
      if (emit) begin
        best_color <= '0;
        best_count <= '0;
      end else if (state == dcr_pkg::ST_BEST && rd_valid && rd_data.count > best_count) begin
        best_color <= rd_data.color;
        best_count <= rd_data.count;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_tag <= rd_addr;
    if (accept) begin
      cur_color <= dcr_pkg::to_argb(pixel_word, mode);
      cur_last  <= row_end;
    end
    if (state == dcr_pkg::ST_SCAN && match) begin
      hit_idx   <= rd_tag;
      hit_count <= rd_data.count;
    end
    if (emit) begin
      dominant_color <= best_color;
      dominant_count <= best_count;
    end
  end

endmodule

// File: rtl/core/dominant_color_of_row.sv
// Dominant color of a row: per pixel, an accept, a search and an update. The search walks
// the table through its single read port, entry by entry, and stops at a hit or after the
// last used entry. A row_end pixel adds a max scan over the used entries; done pulses in
// the cycle after the scan ends, and busy drops in that same cycle. No receiver stall.
// Reset (rst, synchronous) empties the table by clearing the fill count and sets
// byte_order_mode to 0; the table memory itself is not cleared. Depends on dcr_pkg.
module dominant_color_of_row #(
  parameter int MAX_ROW_WIDTH = dcr_pkg::MAX_ROW_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   pixel_word,
  input  logic                          row_end,
  output logic                          done,
  output logic [dcr_pkg::COLOR_W-1:0]   dominant_color,
  output logic [dcr_pkg::COUNT_W-1:0]   dominant_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int ADDR_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int CNT_W  = $clog2(MAX_ROW_WIDTH + 1);

  logic              byte_order_mode;
  dcr_pkg::mem_cmd_t cmd;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  dcr_pkg::entry_t   rd_data;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration register: a single register fills the whole address range
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order_mode <= dcr_pkg::MODE_SWAP_RB;
    end else if (cfg_wr) begin
      byte_order_mode <= pwdata[0];
    end
  end

  // Read back the register, byte offset ignored
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00 || paddr[1:0] != 2'b00) begin
      prdata[dcr_pkg::REG_BYTE_ORDER] = byte_order_mode;
    end
  end

  dcr_ctrl #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .ADDR_W        (ADDR_W),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .pixel_word     (pixel_word),
    .row_end        (row_end),
    .mode           (byte_order_mode),
    .busy           (busy),
    .done           (done),
    .dominant_color (dominant_color),
    .dominant_count (dominant_count),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .rd_data        (rd_data)
  );

  dcr_table #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .ADDR_W        (ADDR_W)
  ) u_table (
    .clk     (clk),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .rd_data (rd_data)
  );

endmodule
